[hw/rtl/jdc_pkg.sv]
// ---------------------------------------------------------------------------
// jdc_pkg
// Shared constants and types for the Julian day to calendar converter.
// ---------------------------------------------------------------------------
package jdc_pkg;

   localparam int NUM_STAGES = 6;

   localparam int JD_W   = 22;
   localparam int FRAC_W = 32;
   localparam int DAY_W  = 17;
   localparam int SOD_W  = 17;
   localparam int YR_W   = 8;

   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int MDAY_W   = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;

   // day count origin: JD of 1 March 1900 is day 1
   localparam logic [23:0] JD_MARCH_1900  = 24'd2415079;
   localparam logic [23:0] LAST_VALID_DAY = 24'd73049;
   localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [16:0] ROUND_BIAS     = 17'd65536;

   // reciprocals, exact over the value ranges seen here
   localparam logic [19:0] RECIP_1461 = 20'd734937;  // >> 30
   localparam logic [18:0] RECIP_3600 = 19'd298262;  // >> 30
   localparam logic [12:0] RECIP_60   = 13'd4370;    // >> 18
   localparam logic [12:0] RECIP_153  = 13'd6854;    // >> 20
   localparam logic [7:0]  RECIP_5    = 8'd205;      // >> 10

   localparam logic [10:0] DAYS_4YR    = 11'd1461;
   localparam logic [11:0] SECS_HOUR   = 12'd3600;
   localparam logic [5:0]  SECS_MINUTE = 6'd60;
   localparam logic [7:0]  DAYS_5MON   = 8'd153;
   localparam logic [11:0] BASE_YEAR   = 12'd1900;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

endpackage

[hw/rtl/julian_day_to_calendar_unit.sv]
// ---------------------------------------------------------------------------
// julian_day_to_calendar_unit
// Julian day number and Q0.32 fraction to Gregorian date and clock time.
// ---------------------------------------------------------------------------
//  channel  dir  tdata fields                       tuser
//  req_     in   julian_day, day_fraction           -
//  rsp_     out  year, month, day, hour, min, sec   range_error
//
//  Six register stages; one transaction per cycle unless the output stalls.
//  The stages after the first hold the reciprocal-multiply chains for
//  year/month/day and hour/minute/second.
//  Synchronous reset clears the valid bits only.
//  Each stage holds while the next is full and stalled; bubbles collapse.
// ---------------------------------------------------------------------------
module julian_day_to_calendar_unit
   import jdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // julian_day[21:0], day_fraction[53:22]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // year[11:0], month[15:12], day[20:16],
                                    // hour[25:21], minute[31:26], second[37:32]
   output logic [0:0]  rsp_tuser    // range_error[0]
);

   pipe_ctrl_type       ctrl;
   logic [FRAC_W-1:0]   civil_frac;
   logic [DAY_W-1:0]    day_count;
   logic                range_err;
   logic [YEAR_W-1:0]   cal_year;
   logic [MONTH_W-1:0]  cal_month;
   logic [MDAY_W-1:0]   cal_day;
   logic [HOUR_W-1:0]   clock_hour;
   logic [MINUTE_W-1:0] clock_minute;
   logic [SECOND_W-1:0] clock_second;
   logic                range_error;

   jdc_pipe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   jdc_front u_front (
      .clock        (clock),
      .ctrl         (ctrl),
      .julian_day   (req_tdata[21:0]),
      .day_fraction (req_tdata[53:22]),
      .civil_frac   (civil_frac),
      .day_count    (day_count),
      .range_err    (range_err)
   );

   jdc_time_path u_time (
      .clock        (clock),
      .ctrl         (ctrl),
      .civil_frac   (civil_frac),
      .clock_hour   (clock_hour),
      .clock_minute (clock_minute),
      .clock_second (clock_second)
   );

   jdc_date_path u_date (
      .clock       (clock),
      .ctrl        (ctrl),
      .day_count   (day_count),
      .range_err   (range_err),
      .cal_year    (cal_year),
      .cal_month   (cal_month),
      .cal_day     (cal_day),
      .range_error (range_error)
   );

   assign rsp_tdata = {2'b00, clock_second, clock_minute, clock_hour,
                       cal_day, cal_month, cal_year};
   assign rsp_tuser = range_error;

`ifndef NO_ASSERTIONS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 40'd0))
      else $error("range error with nonzero fields");

   a_month_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |->
         (rsp_tdata[15:12] != 4'd0 && rsp_tdata[15:12] <= 4'd12 &&
          rsp_tdata[20:16] != 5'd0))
      else $error("month or day out of range");

   a_time_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[25:21] <= 5'd23 && rsp_tdata[31:26] <= 6'd59 &&
                      rsp_tdata[37:32] <= 6'd59))
      else $error("time of day out of range");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output drains");
`endif

endmodule

[hw/rtl/jdc_pipe_ctrl.sv]
// ---------------------------------------------------------------------------
// jdc_pipe_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// the stage after it moves on.
// ---------------------------------------------------------------------------
module jdc_pipe_ctrl
   import jdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output pipe_ctrl_type ctrl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] ready;

   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      valid_in[0] = ready[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load  = ready;
   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

endmodule

[hw/rtl/jdc_front.sv]
// ---------------------------------------------------------------------------
// jdc_front
// First stage: half-day shift, day count from March 1900, range check.
// ---------------------------------------------------------------------------
module jdc_front
   import jdc_pkg::*;
(
   input  logic              clock,
   input  pipe_ctrl_type     ctrl,
   input  logic [JD_W-1:0]   julian_day,
   input  logic [FRAC_W-1:0] day_fraction,
   output logic [FRAC_W-1:0] civil_frac,
   output logic [DAY_W-1:0]  day_count,
   output logic              range_err
);

   logic [FRAC_W-1:0] g_ff, g_in;
   logic [DAY_W-1:0]  d_ff, d_in;
   logic              err_ff, err_in;
   logic [23:0]       d_full;

   always_comb begin
      d_full = 24'(julian_day) + 24'(day_fraction[FRAC_W-1]) - JD_MARCH_1900;
      err_in = d_full[23] || (d_full == 24'd0) || (!d_full[23] && d_full > LAST_VALID_DAY);
      d_in   = d_full[DAY_W-1:0];
      // zero fraction makes every time field zero on an error
      g_in   = err_in ? '0 : {~day_fraction[FRAC_W-1], day_fraction[FRAC_W-2:0]};
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         g_ff   <= g_in;
         d_ff   <= d_in;
         err_ff <= err_in;
      end
   end

   assign civil_frac = g_ff;
   assign day_count  = d_ff;
   assign range_err  = err_ff;

endmodule

[hw/rtl/jdc_time_path.sv]
// ---------------------------------------------------------------------------
// jdc_time_path
// Seconds of day, then hour and minute by reciprocal multiplies, second as remainder.
// ---------------------------------------------------------------------------
module jdc_time_path
   import jdc_pkg::*;
(
   input  logic                clock,
   input  pipe_ctrl_type       ctrl,
   input  logic [FRAC_W-1:0]   civil_frac,
   output logic [HOUR_W-1:0]   clock_hour,
   output logic [MINUTE_W-1:0] clock_minute,
   output logic [SECOND_W-1:0] clock_second
);

   // stage 2
   logic [SOD_W-1:0]    s2_sod_ff, s2_sod_in;
   logic [48:0]         s2_prod;
   // stage 3
   logic [SOD_W-1:0]    s3_sod_ff;
   logic [HOUR_W-1:0]   s3_hour_ff, s3_hour_in;
   logic [35:0]         s3_prod;
   // stage 4
   logic [HOUR_W-1:0]   s4_hour_ff;
   logic [11:0]         s4_rs_ff, s4_rs_in;
   logic [SOD_W-1:0]    s4_diff;
   // stage 5
   logic [HOUR_W-1:0]   s5_hour_ff;
   logic [11:0]         s5_rs_ff;
   logic [MINUTE_W-1:0] s5_min_ff, s5_min_in;
   logic [24:0]         s5_prod;
   // stage 6
   logic [HOUR_W-1:0]   s6_hour_ff;
   logic [MINUTE_W-1:0] s6_min_ff;
   logic [SECOND_W-1:0] s6_sec_ff, s6_sec_in;
   logic [11:0]         s6_diff;

   always_comb begin
      s2_prod   = 49'(civil_frac) * 49'(SECS_PER_DAY) + 49'(ROUND_BIAS);
      s2_sod_in = s2_prod[48:32];

      s3_prod    = 36'(s2_sod_ff) * 36'(RECIP_3600);
      s3_hour_in = s3_prod[34:30];

      s4_diff  = s3_sod_ff - 17'(17'(s3_hour_ff) * 17'(SECS_HOUR));
      s4_rs_in = s4_diff[11:0];

      s5_prod   = 25'(s4_rs_ff) * 25'(RECIP_60);
      s5_min_in = s5_prod[23:18];

      s6_diff   = s5_rs_ff - 12'(12'(s5_min_ff) * 12'(SECS_MINUTE));
      s6_sec_in = s6_diff[SECOND_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         s2_sod_ff <= s2_sod_in;
      end
      if (ctrl.load[2]) begin
         s3_sod_ff  <= s2_sod_ff;
         s3_hour_ff <= s3_hour_in;
      end
      if (ctrl.load[3]) begin
         s4_hour_ff <= s3_hour_ff;
         s4_rs_ff   <= s4_rs_in;
      end
      if (ctrl.load[4]) begin
         s5_hour_ff <= s4_hour_ff;
         s5_rs_ff   <= s4_rs_ff;
         s5_min_ff  <= s5_min_in;
      end
      if (ctrl.load[5]) begin
         s6_hour_ff <= s5_hour_ff;
         s6_min_ff  <= s5_min_ff;
         s6_sec_ff  <= s6_sec_in;
      end
   end

   assign clock_hour   = s6_hour_ff;
   assign clock_minute = s6_min_ff;
   assign clock_second = s6_sec_ff;

endmodule

[hw/rtl/jdc_date_path.sv]
// ---------------------------------------------------------------------------
// jdc_date_path
// 1461/153 day-count arithmetic from March 1900 to year, month and day.
// ---------------------------------------------------------------------------
module jdc_date_path
   import jdc_pkg::*;
(
   input  logic               clock,
   input  pipe_ctrl_type      ctrl,
   input  logic [DAY_W-1:0]   day_count,
   input  logic               range_err,
   output logic [YEAR_W-1:0]  cal_year,
   output logic [MONTH_W-1:0] cal_month,
   output logic [MDAY_W-1:0]  cal_day,
   output logic               range_error
);

   // stage 2
   logic [18:0]        s2_n_ff, s2_n_in;
   logic [YR_W-1:0]    s2_yr_ff, s2_yr_in;
   logic               s2_err_ff;
   logic [38:0]        s2_prod;
   // stage 3
   logic [YR_W-1:0]    s3_yr_ff;
   logic [10:0]        s3_x_ff, s3_x_in;
   logic               s3_err_ff;
   logic [18:0]        s3_rem;
   logic [8:0]         s3_tday;
   // stage 4
   logic [YR_W-1:0]    s4_yr_ff;
   logic [10:0]        s4_x_ff;
   logic [MONTH_W-1:0] s4_mon_ff, s4_mon_in;
   logic               s4_err_ff;
   logic [23:0]        s4_prod;
   // stage 5
   logic [YR_W-1:0]    s5_yr_ff;
   logic [MONTH_W-1:0] s5_mon_ff;
   logic [7:0]         s5_rem_ff, s5_rem_in;
   logic               s5_err_ff;
   logic [10:0]        s5_diff;
   // stage 6
   logic [YEAR_W-1:0]  s6_year_ff, s6_year_in;
   logic [MONTH_W-1:0] s6_mon_ff, s6_mon_in;
   logic [MDAY_W-1:0]  s6_day_ff, s6_day_in;
   logic               s6_err_ff;
   logic [15:0]        s6_prod;

   always_comb begin
      s2_n_in  = {day_count, 2'b00} - 19'd1;
      s2_prod  = 39'(s2_n_in) * 39'(RECIP_1461);
      s2_yr_in = s2_prod[37:30];

      s3_rem  = s2_n_ff - 19'(19'(s2_yr_ff) * 19'(DAYS_4YR));
      s3_tday = s3_rem[10:2] + 9'd1;
      s3_x_in = 11'(s3_tday) * 11'd5 - 11'd3;

      s4_prod   = 24'(s3_x_ff) * 24'(RECIP_153);
      s4_mon_in = s4_prod[23:20];

      s5_diff   = s4_x_ff - 11'(11'(s4_mon_ff) * 11'(DAYS_5MON));
      s5_rem_in = s5_diff[7:0];

      s6_prod   = 16'(s5_rem_ff) * 16'(RECIP_5);
      s6_day_in = s6_prod[14:10] + 5'd1;
      if (s5_mon_ff >= 4'd10) begin
         s6_mon_in  = s5_mon_ff - 4'd9;
         s6_year_in = BASE_YEAR + 12'(s5_yr_ff) + 12'd1;
      end else begin
         s6_mon_in  = s5_mon_ff + 4'd3;
         s6_year_in = BASE_YEAR + 12'(s5_yr_ff);
      end
      if (s5_err_ff) begin
         s6_mon_in  = '0;
         s6_year_in = '0;
         s6_day_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         s2_n_ff   <= s2_n_in;
         s2_yr_ff  <= s2_yr_in;
         s2_err_ff <= range_err;
      end
      if (ctrl.load[2]) begin
         s3_yr_ff  <= s2_yr_ff;
         s3_x_ff   <= s3_x_in;
         s3_err_ff <= s2_err_ff;
      end
      if (ctrl.load[3]) begin
         s4_yr_ff  <= s3_yr_ff;
         s4_x_ff   <= s3_x_ff;
         s4_mon_ff <= s4_mon_in;
         s4_err_ff <= s3_err_ff;
      end
      if (ctrl.load[4]) begin
         s5_yr_ff  <= s4_yr_ff;
         s5_mon_ff <= s4_mon_ff;
         s5_rem_ff <= s5_rem_in;
         s5_err_ff <= s4_err_ff;
      end
      if (ctrl.load[5]) begin
         s6_year_ff <= s6_year_in;
         s6_mon_ff  <= s6_mon_in;
         s6_day_ff  <= s6_day_in;
         s6_err_ff  <= s5_err_ff;
      end
   end

   assign cal_year    = s6_year_ff;
   assign cal_month   = s6_mon_ff;
   assign cal_day     = s6_day_ff;
   assign range_error = s6_err_ff;

endmodule
